### hdl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg: shared constants and helpers of the discounted return standardizer
// Formats, reset values and the saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int MAX_FRAMES_DEF = 64;

  localparam logic [15:0] DISCOUNT_RESET = 16'd65208;

  // Accumulator widths that cover the largest episode.
  localparam int SUM_W = 31;  // sum of returns
  localparam int SQ_W  = 53;  // sum of squared returns
  localparam int NQ_W  = 60;  // frame count times sum of squares
  localparam int DIV_W = 48;  // dividend of the shared divider
  localparam int DEN_W = 32;  // divisor of the shared divider

  localparam logic signed [63:0] R24_MAX = 64'sd8388607;
  localparam logic signed [63:0] R24_MIN = -64'sd8388608;
  localparam logic signed [63:0] R20_MAX = 64'sd524287;
  localparam logic signed [63:0] R20_MIN = -64'sd524288;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > R24_MAX) c = R24_MAX;
    if (v < R24_MIN) c = R24_MIN;
    return c[23:0];
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > R20_MAX) c = R20_MAX;
    if (v < R20_MIN) c = R20_MIN;
    return c[19:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

endpackage

### hdl/discounted_return_standardizer.sv
// ----------------------------------------------------------------------------
// discounted_return_standardizer: episode returns with z-score normalization
// Stores one episode of rewards, forms backward discounted returns, then emits
// each return with its scaled value, its advantage and the episode mean.
// ----------------------------------------------------------------------------
// A reward is taken while the block is idle; items not marked last give no
// result. The item marked last starts the episode pass, during which busy is
// high: it forms the discounted returns, then the sums, the variance, the
// square root and the mean, then the results, for which the 48-step shared
// divider runs twice per frame (no division is needed when all returns are
// equal).
// Each result is shown for one cycle with result_valid and cannot be stalled,
// so the receiver must take it on that cycle. Frames beyond MAX_FRAMES are
// dropped and reported through the overflow field of that episode.
module discounted_return_standardizer #(
  parameter int MAX_FRAMES = drs_pkg::MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] reward,
  input  logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               result_valid,
  output logic [5:0]         frame_index,
  output logic signed [23:0] discounted_return,
  output logic signed [19:0] scaled_return,
  output logic signed [19:0] advantage,
  output logic signed [23:0] mean_return,
  output logic               overflow,
  output logic               last_result
);
  import drs_pkg::*;

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_B_RD    = 5'd1;
  localparam logic [4:0] ST_B_MUL   = 5'd2;
  localparam logic [4:0] ST_B_WR    = 5'd3;
  localparam logic [4:0] ST_S_RD    = 5'd4;
  localparam logic [4:0] ST_S_MUL   = 5'd5;
  localparam logic [4:0] ST_S_ACC   = 5'd6;
  localparam logic [4:0] ST_NQ      = 5'd7;
  localparam logic [4:0] ST_SSQ     = 5'd8;
  localparam logic [4:0] ST_VAR     = 5'd9;
  localparam logic [4:0] ST_SQRT    = 5'd10;
  localparam logic [4:0] ST_MEAN    = 5'd11;
  localparam logic [4:0] ST_DIV     = 5'd12;
  localparam logic [4:0] ST_DIV_END = 5'd13;
  localparam logic [4:0] ST_O_RD    = 5'd14;
  localparam logic [4:0] ST_O_MUL   = 5'd15;
  localparam logic [4:0] ST_O_SC    = 5'd16;

  localparam logic [1:0] DSEL_MEAN = 2'd0;
  localparam logic [1:0] DSEL_SC   = 2'd1;
  localparam logic [1:0] DSEL_AD   = 2'd2;

  logic [4:0]              state;
  logic [CW-1:0]           frame_count;
  logic                    ovf;
  logic [15:0]             discount;
  logic [CW-1:0]           k;
  logic [5:0]              cnt;
  logic signed [23:0]      next_ret;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sq;
  logic [NQ_W-1:0]         nq;
  logic [63:0]             rad;
  logic [63:0]             res;
  logic [63:0]             sbit;
  logic [DEN_W-1:0]        dev;
  logic [DIV_W-1:0]        dq;
  logic [DEN_W-1:0]        drem;
  logic [DEN_W-1:0]        dden;
  logic                    dneg;
  logic [1:0]              dsel;
  logic signed [23:0]      mean;
  logic signed [19:0]      sc;
  logic signed [23:0]      r_cur;
  logic signed [SUM_W-1:0] rn;

  logic signed [23:0] mem [MAX_FRAMES];
  logic signed [23:0] rdata;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic signed [23:0] mem_wdata;

  // The one multiplier, shared by the return, sum, variance and output phases.
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;

  logic signed [63:0] bsum;
  logic               nq_bit;
  logic [63:0]        sq_try;
  logic [DEN_W:0]     rem_sh;
  logic signed [63:0] q_signed;
  logic signed [63:0] rn_now;
  logic signed [63:0] sc_num;
  logic signed [63:0] ad_num;
  logic               is_last_k;
  logic               result_valid_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_B_MUL: begin
        mul_a = {16'd0, discount};
        mul_b = 32'(next_ret);
      end
      ST_S_MUL: begin
        mul_a = 32'(rdata);
        mul_b = 32'(rdata);
      end
      ST_SSQ: begin
        mul_a = 32'(sum);
        mul_b = 32'(sum);
      end
      ST_O_MUL: begin
        mul_a = 32'(rdata);
        mul_b = {{(32 - CW){1'b0}}, frame_count};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_addr  = k[AW-1:0];
    mem_we    = 1'b0;
    mem_wdata = sat24(bsum);
    if (state == ST_IDLE) begin
      mem_addr  = frame_count[AW-1:0];
      mem_we    = start && (frame_count < CW'(MAX_FRAMES));
      mem_wdata = 24'(reward);
    end else if (state == ST_B_WR) begin
      mem_we = 1'b1;
    end
  end

  // Rounding half up of discount * next, then the stored reward is added.
  assign bsum      = ((prod + 64'sd32768) >>> 16) + 64'(rdata);
  assign nq_bit    = |((frame_count >> cnt) & CW'(1));
  assign sq_try    = res + sbit;
  assign rem_sh    = {drem, dq[DIV_W-1]};
  assign q_signed  = dneg ? -$signed({16'd0, dq}) : $signed({16'd0, dq});
  assign rn_now    = {{33{prod[30]}}, prod[30:0]};
  assign sc_num    = rn_now <<< 14;
  assign ad_num    = (64'(rn) - 64'(sum)) <<< 14;
  assign is_last_k = ((k + CW'(1)) == frame_count);

  // A result leaves after the advantage division, or directly when the
  // deviation is zero.
  assign result_valid_next = ((state == ST_DIV_END) && (dsel == DSEL_AD)) ||
                             ((state == ST_O_SC) && (dev == '0));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_count  <= '0;
      ovf          <= 1'b0;
      discount     <= DISCOUNT_RESET;
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (cfg_valid && cfg_ready) begin
        discount <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (frame_count < CW'(MAX_FRAMES)) begin
              frame_count <= frame_count + CW'(1);
              k           <= frame_count;
            end else begin
              ovf <= 1'b1;
              k   <= frame_count - CW'(1);
            end
            next_ret <= '0;
            if (last) begin
              state <= ST_B_RD;
            end
          end
        end
        ST_B_RD:  state <= ST_B_MUL;
        ST_B_MUL: state <= ST_B_WR;
        ST_B_WR: begin
          next_ret <= sat24(bsum);
          if (k == '0) begin
            sum   <= '0;
            sq    <= '0;
            state <= ST_S_RD;
          end else begin
            k     <= k - CW'(1);
            state <= ST_B_RD;
          end
        end
        ST_S_RD: state <= ST_S_MUL;
        ST_S_MUL: begin
          sum   <= sum + SUM_W'(rdata);
          state <= ST_S_ACC;
        end
        ST_S_ACC: begin
          sq <= sq + prod[SQ_W-1:0];
          if (is_last_k) begin
            nq    <= '0;
            cnt   <= '0;
            state <= ST_NQ;
          end else begin
            k     <= k + CW'(1);
            state <= ST_S_RD;
          end
        end
        ST_NQ: begin
          // Shift-and-add of the frame count against the sum of squares.
          if (nq_bit) begin
            nq <= nq + (NQ_W'(sq) << cnt);
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(CW - 1)) begin
            state <= ST_SSQ;
          end
        end
        ST_SSQ: state <= ST_VAR;
        ST_VAR: begin
          rad   <= {nq - prod[NQ_W-1:0], 4'd0};
          res   <= '0;
          sbit  <= 64'd1 << 62;
          cnt   <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (rad >= sq_try) begin
            rad <= rad - sq_try;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          dev   <= res[DEN_W-1:0];
          dq    <= DIV_W'(mag64(64'(sum))) + DIV_W'(frame_count >> 1);
          dden  <= DEN_W'(frame_count);
          dneg  <= sum[SUM_W-1];
          drem  <= '0;
          dsel  <= DSEL_MEAN;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (rem_sh >= {1'b0, dden}) begin
            drem <= DEN_W'(rem_sh - {1'b0, dden});
            dq   <= {dq[DIV_W-2:0], 1'b1};
          end else begin
            drem <= rem_sh[DEN_W-1:0];
            dq   <= {dq[DIV_W-2:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DIV_W - 1)) begin
            state <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          unique case (dsel)
            DSEL_MEAN: begin
              mean  <= sat24(q_signed);
              k     <= '0;
              state <= ST_O_RD;
            end
            DSEL_SC: begin
              sc    <= sat20(q_signed);
              dq    <= DIV_W'(mag64(ad_num)) + DIV_W'(dev >> 1);
              dneg  <= ad_num[63];
              drem  <= '0;
              dsel  <= DSEL_AD;
              cnt   <= '0;
              state <= ST_DIV;
            end
            default: begin
              frame_index       <= 6'(k);
              discounted_return <= r_cur;
              scaled_return     <= sc;
              advantage         <= sat20(q_signed);
              mean_return       <= mean;
              overflow          <= ovf;
              last_result       <= is_last_k;
              if (is_last_k) begin
                frame_count <= '0;
                ovf         <= 1'b0;
                state       <= ST_IDLE;
              end else begin
                k     <= k + CW'(1);
                state <= ST_O_RD;
              end
            end
          endcase
        end
        ST_O_RD: state <= ST_O_MUL;
        ST_O_MUL: begin
          r_cur <= rdata;
          state <= ST_O_SC;
        end
        ST_O_SC: begin
          rn <= prod[SUM_W-1:0];
          if (dev == '0) begin
            // All returns equal: both normalized fields take the return shifted left by four, saturated.
            frame_index       <= 6'(k);
            discounted_return <= r_cur;
            scaled_return     <= sat20(64'(r_cur) <<< 4);
            advantage         <= sat20(64'(r_cur) <<< 4);
            mean_return       <= mean;
            overflow          <= ovf;
            last_result       <= is_last_k;
            if (is_last_k) begin
              frame_count <= '0;
              ovf         <= 1'b0;
              state       <= ST_IDLE;
            end else begin
              k     <= k + CW'(1);
              state <= ST_O_RD;
            end
          end else begin
            dq    <= DIV_W'(mag64(sc_num)) + DIV_W'(dev >> 1);
            dden  <= dev;
            dneg  <= sc_num[63];
            drem  <= '0;
            dsel  <= DSEL_SC;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_plain_item_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !busy)
    else $error("an item not marked last left the block busy");

  a_more_results_follow: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |-> busy)
    else $error("block went idle before the final result of the episode");

  a_final_result_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |-> !busy)
    else $error("block still busy after the final result of the episode");

endmodule
